// ===== design/prf_pkg.sv =====
`default_nettype none
package prf_pkg;
    localparam int unsigned Width     = 32;
    localparam int unsigned MaxItBits = 20;
    localparam logic [MaxItBits-1:0] MaxItReset = 20'd65535;

    typedef logic [Width-1:0] word_t;

    typedef enum logic [1:0] {
        ST_FOUND    = 2'd0,
        ST_ONE      = 2'd1,
        ST_COLLAPSE = 2'd2,
        ST_LIMIT    = 2'd3
    } status_t;

    // Operations of the shared modular unit.
    typedef enum logic [1:0] {
        OP_MULMOD = 2'd0,
        OP_ADDMOD = 2'd1,
        OP_MOD    = 2'd2
    } op_t;

    typedef enum logic [3:0] {
        S_IDLE, S_RED_X, S_RED_C, S_CHECK, S_SQ, S_ADD, S_DIFF,
        S_GCD_MOD, S_GCD_WAIT, S_JUDGE, S_DONE, S_WAIT_SQ, S_WAIT_ADD, S_WAIT_RED
    } state_t;
endpackage
`default_nettype wire

// ===== design/pollard_rho_factor_finder_core.sv =====
`default_nettype none
// Channel   | Ports                                       | Direction
// input     | s_valid s_ready s_number s_start_value s_increment | in
// result    | m_valid m_ready m_factor m_status           | out
// config    | cfg_we cfg_wdata (max_iterations)            | in
// One item at a time; s_ready is low from acceptance until the result is taken.
// Each modular operation runs in the shared unit; one round consists of three
// squarings, three additions and one gcd of up to ~46 modulo steps. One and even
// numbers skip the unit and go straight to the result.
// Reset is synchronous and active low and loads max_iterations with 65535.
// A stalled result holds in its register while m_ready is low.
module pollard_rho_factor_finder_core (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               s_valid,
    output logic                                    s_ready,
    input  wire prf_pkg::word_t                     s_number,
    input  wire prf_pkg::word_t                     s_start_value,
    input  wire prf_pkg::word_t                     s_increment,
    output logic                                    m_valid,
    input  wire logic                               m_ready,
    output prf_pkg::word_t                          m_factor,
    output logic [1:0]                              m_status,
    input  wire logic                               cfg_we,
    input  wire logic [prf_pkg::MaxItBits-1:0]      cfg_wdata
);
    prf_pkg::state_t state_reg, state_next, ret_reg, ret_next;
    logic [prf_pkg::MaxItBits-1:0] maxit_reg, round_reg, round_next;
    prf_pkg::word_t n_reg, n_next, x_reg, x_next, y_reg, y_next, c_reg, c_next;
    prf_pkg::word_t g_reg, g_next, h_reg, h_next, seed_reg, seed_next;
    prf_pkg::word_t fac_reg, fac_next;
    logic [1:0] sq_reg, sq_next;   // 0: x, 1: y first, 2: y second
    logic [1:0] st_reg, st_next;
    logic       mv_reg, mv_next;

    logic           u_start;
    prf_pkg::op_t   u_op;
    prf_pkg::word_t u_a, u_b, u_n, u_res;
    logic           u_done;
    prf_pkg::word_t cur;

    prf_modunit u_mod (
        .aclk, .aresetn, .start(u_start), .op(u_op), .a(u_a), .b(u_b),
        .n(u_n), .done(u_done), .result(u_res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= prf_pkg::S_IDLE;
            maxit_reg <= prf_pkg::MaxItReset;
            mv_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            mv_reg    <= mv_next;
            if (cfg_we) maxit_reg <= cfg_wdata;
        end
        ret_reg   <= ret_next;
        round_reg <= round_next;
        n_reg <= n_next; x_reg <= x_next; y_reg <= y_next; c_reg <= c_next;
        g_reg <= g_next; h_reg <= h_next; seed_reg <= seed_next;
        fac_reg <= fac_next; sq_reg <= sq_next; st_reg <= st_next;
    end

    assign cur = (sq_reg == 2'd0) ? x_reg : y_reg;

    always_comb begin
        state_next = state_reg; ret_next = ret_reg; round_next = round_reg;
        n_next = n_reg; x_next = x_reg; y_next = y_reg; c_next = c_reg;
        g_next = g_reg; h_next = h_reg; seed_next = seed_reg;
        fac_next = fac_reg; sq_next = sq_reg; st_next = st_reg;
        mv_next = mv_reg;
        u_start = 1'b0; u_op = prf_pkg::OP_MOD; u_a = '0; u_b = '0; u_n = n_reg;
        s_ready = 1'b0;
        case (state_reg)
            prf_pkg::S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    n_next    = s_number;
                    seed_next = s_start_value;
                    c_next    = s_increment;
                    fac_next  = s_number;
                    if (s_number == prf_pkg::word_t'(1)) begin
                        fac_next = s_number; st_next = prf_pkg::ST_ONE;
                        state_next = prf_pkg::S_DONE;
                    end else if (!s_number[0]) begin
                        fac_next = prf_pkg::word_t'(2); st_next = prf_pkg::ST_FOUND;
                        state_next = prf_pkg::S_DONE;
                    end else begin
                        state_next = prf_pkg::S_RED_X;
                    end
                end
            end
            prf_pkg::S_RED_X: begin
                u_start = 1'b1; u_a = seed_reg;
                ret_next = prf_pkg::S_RED_C; state_next = prf_pkg::S_WAIT_RED;
            end
            prf_pkg::S_RED_C: begin
                x_next = u_res; y_next = u_res;
                u_start = 1'b1; u_a = c_reg;
                ret_next = prf_pkg::S_CHECK; state_next = prf_pkg::S_WAIT_RED;
            end
            prf_pkg::S_WAIT_RED: begin
                if (u_done) begin
                    if (ret_reg == prf_pkg::S_CHECK) c_next = u_res;
                    state_next = ret_reg;
                end
            end
            prf_pkg::S_CHECK: begin
                round_next = '0;
                sq_next = 2'd0;
                if (maxit_reg == '0) begin
                    st_next = prf_pkg::ST_LIMIT; state_next = prf_pkg::S_DONE;
                end else begin
                    state_next = prf_pkg::S_SQ;
                end
            end
            prf_pkg::S_SQ: begin
                u_start = 1'b1; u_op = prf_pkg::OP_MULMOD; u_a = cur; u_b = cur;
                state_next = prf_pkg::S_WAIT_SQ;
            end
            prf_pkg::S_WAIT_SQ: begin
                if (u_done) state_next = prf_pkg::S_ADD;
            end
            prf_pkg::S_ADD: begin
                u_start = 1'b1; u_op = prf_pkg::OP_ADDMOD; u_a = u_res; u_b = c_reg;
                state_next = prf_pkg::S_WAIT_ADD;
            end
            prf_pkg::S_WAIT_ADD: begin
                if (u_done) begin
                    if (sq_reg == 2'd0) x_next = u_res; else y_next = u_res;
                    if (sq_reg == 2'd2) begin
                        state_next = prf_pkg::S_DIFF;
                    end else begin
                        sq_next = sq_reg + 2'd1;
                        state_next = prf_pkg::S_SQ;
                    end
                end
            end
            prf_pkg::S_DIFF: begin
                g_next = n_reg;
                h_next = (x_reg >= y_reg) ? (x_reg - y_reg) : (y_reg - x_reg);
                state_next = prf_pkg::S_GCD_MOD;
            end
            prf_pkg::S_GCD_MOD: begin
                // Euclid on (g, h): stop when h reaches zero.
                if (h_reg == '0) begin
                    state_next = prf_pkg::S_JUDGE;
                end else begin
                    u_start = 1'b1; u_a = g_reg; u_n = h_reg;
                    state_next = prf_pkg::S_GCD_WAIT;
                end
            end
            prf_pkg::S_GCD_WAIT: begin
                u_op = prf_pkg::OP_MOD;
                if (u_done) begin
                    g_next = h_reg; h_next = u_res;
                    state_next = prf_pkg::S_GCD_MOD;
                end
            end
            prf_pkg::S_JUDGE: begin
                sq_next = 2'd0;
                if (g_reg == n_reg) begin
                    st_next = prf_pkg::ST_COLLAPSE; fac_next = n_reg;
                    state_next = prf_pkg::S_DONE;
                end else if (g_reg != prf_pkg::word_t'(1)) begin
                    st_next = prf_pkg::ST_FOUND; fac_next = g_reg;
                    state_next = prf_pkg::S_DONE;
                end else if (round_reg + prf_pkg::MaxItBits'(1) >= maxit_reg) begin
                    st_next = prf_pkg::ST_LIMIT; fac_next = n_reg;
                    state_next = prf_pkg::S_DONE;
                end else begin
                    round_next = round_reg + prf_pkg::MaxItBits'(1);
                    state_next = prf_pkg::S_SQ;
                end
            end
            prf_pkg::S_DONE: begin
                if (!mv_reg) begin
                    mv_next = 1'b1;
                end else if (m_ready) begin
                    mv_next = 1'b0;
                    state_next = prf_pkg::S_IDLE;
                end
            end
            default: state_next = prf_pkg::S_IDLE;
        endcase
    end

    assign m_valid  = mv_reg;
    assign m_factor = fac_reg;
    assign m_status = st_reg;
endmodule
`default_nettype wire

// ===== design/prf_modunit.sv =====
`default_nettype none
// Shared modular unit: computes (a*b) mod n, (a+b) mod n or a mod n.
// The multiply is one registered 32x32 product; the reduction is a
// restoring division that retires one quotient bit per cycle.
module prf_modunit (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                start,
    input  wire prf_pkg::op_t        op,
    input  wire prf_pkg::word_t      a,
    input  wire prf_pkg::word_t      b,
    input  wire prf_pkg::word_t      n,
    output logic                     done,
    output prf_pkg::word_t           result
);
    localparam int unsigned W2 = 2 * prf_pkg::Width;
    localparam int unsigned CntW = $clog2(W2 + 1);

    logic [W2-1:0]           num_reg, num_next;
    logic [prf_pkg::Width:0] rem_reg, rem_next;
    prf_pkg::word_t          den_reg, den_next;
    logic [CntW-1:0]         cnt_reg, cnt_next;
    logic                    busy_reg, busy_next;
    logic                    mul_reg, mul_next;
    logic                    done_reg, done_next;
    prf_pkg::word_t          a_reg, a_next, b_reg, b_next;
    logic [prf_pkg::Width:0] trial;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            mul_reg  <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            mul_reg  <= mul_next;
            done_reg <= done_next;
        end
        num_reg <= num_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
        cnt_reg <= cnt_next;
        a_reg   <= a_next;
        b_reg   <= b_next;
    end

    assign trial = {rem_reg[prf_pkg::Width-1:0], num_reg[W2-1]} - {1'b0, den_reg};

    always_comb begin
        num_next  = num_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        mul_next  = 1'b0;
        done_next = 1'b0;
        a_next    = a_reg;
        b_next    = b_reg;
        if (start) begin
            den_next = n;
            rem_next = '0;
            a_next   = a;
            b_next   = b;
            case (op)
                prf_pkg::OP_MULMOD: begin
                    mul_next = 1'b1;
                end
                prf_pkg::OP_ADDMOD: begin
                    num_next  = W2'({1'b0, a} + {1'b0, b});
                    cnt_next  = CntW'(W2);
                    busy_next = 1'b1;
                end
                default: begin
                    num_next  = W2'(a);
                    cnt_next  = CntW'(W2);
                    busy_next = 1'b1;
                end
            endcase
        end else if (mul_reg) begin
            num_next  = W2'(a_reg) * W2'(b_reg);
            cnt_next  = CntW'(W2);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            num_next = {num_reg[W2-2:0], 1'b0};
            if (!trial[prf_pkg::Width]) begin
                rem_next = trial;
            end else begin
                rem_next = {rem_reg[prf_pkg::Width-1:0], num_reg[W2-1]};
            end
            cnt_next = cnt_reg - CntW'(1);
            if (cnt_reg == CntW'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    assign done   = done_reg;
    assign result = rem_reg[prf_pkg::Width-1:0];
endmodule
`default_nettype wire

// ===== design/prf_checker.sv =====
`default_nettype none
module prf_core_props (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_valid,
    input wire logic        s_ready,
    input wire logic [31:0] s_number,
    input wire logic        m_valid,
    input wire logic        m_ready,
    input wire logic [31:0] m_factor,
    input wire logic [1:0]  m_status
);
    // No new item is taken while a result is offered.
    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !s_ready) else $error("input ready while result pending");
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_factor) && $stable(m_status))
        else $error("stalled result changed");
    // One and even numbers are answered directly: even ones with factor two, one with status one.
    a_even: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && !s_number[0] |=> ##1 m_valid && m_factor == 32'd2)
        else $error("even number not answered with two");
    a_one: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_number == 32'd1 |=> ##1 m_valid && m_status == 2'd1)
        else $error("number one not answered");
endmodule

bind pollard_rho_factor_finder_core prf_core_props u_prf_checker (
    .aclk, .aresetn, .s_valid, .s_ready, .s_number,
    .m_valid, .m_ready, .m_factor, .m_status
);
`default_nettype wire

// ===== tb/prf_checker.sv =====
`timescale 1ns / 1ps
module prf_checker (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_valid,
    input  wire logic                          s_ready,
    input  wire prf_pkg::word_t                s_number,
    input  wire prf_pkg::word_t                s_start_value,
    input  wire prf_pkg::word_t                s_increment,
    input  wire logic                          m_valid,
    input  wire logic                          m_ready,
    input  wire prf_pkg::word_t                m_factor,
    input  wire logic [1:0]                    m_status,
    input  wire logic                          cfg_we,
    input  wire logic [prf_pkg::MaxItBits-1:0] cfg_wdata,
    output int                                 errors,
    output int                                 pending
);
    typedef struct packed {
        prf_pkg::word_t   factor;
        prf_pkg::status_t status;
    } split_t;

    split_t                        split_q[$];
    logic [prf_pkg::MaxItBits-1:0] round_limit;

    // Floyd rho on x -> x*x + c mod n; 64-bit math keeps the products exact.
    function automatic split_t rho_split(input prf_pkg::word_t n, input prf_pkg::word_t sv,
                                         input prf_pkg::word_t inc,
                                         input logic [prf_pkg::MaxItBits-1:0] lim);
        longint unsigned nn, x, y, c, a, b, t;
        int unsigned     r;
        split_t          res;
        nn = n;
        res.factor = n;
        res.status = prf_pkg::ST_LIMIT;
        if (n == 1) begin
            res.factor = 1;
            res.status = prf_pkg::ST_ONE;
        end else if (!n[0]) begin
            res.factor = 2;
            res.status = prf_pkg::ST_FOUND;
        end else begin
            x = sv % nn;
            y = x;
            c = inc % nn;
            for (r = 0; r < lim; r++) begin
                x = (x * x + c) % nn;
                y = (y * y + c) % nn;
                y = (y * y + c) % nn;
                a = (x >= y) ? x - y : y - x;
                b = nn;
                // gcd(a, n); a zero difference yields n itself.
                while (a != 0) begin
                    t = b % a;
                    b = a;
                    a = t;
                end
                if (b == nn) begin
                    res.status = prf_pkg::ST_COLLAPSE;
                    break;
                end
                if (b != 1) begin
                    res.factor = prf_pkg::word_t'(b);
                    res.status = prf_pkg::ST_FOUND;
                    break;
                end
            end
        end
        return res;
    endfunction

    task automatic report(input string what, input longint got, input longint want);
        $display("ERROR %0t: %s got %0d expected %0d", $time, what, got, want);
        errors++;
    endtask

    initial begin
        errors  = 0;
        pending = 0;
        round_limit = prf_pkg::MaxItReset;
    end

    always @(posedge aclk) begin
        split_t exp_split;
        int     delta;
        delta = 0;
        if (!aresetn) begin
            round_limit <= prf_pkg::MaxItReset;
        end else begin
            if (cfg_we) begin
                round_limit <= cfg_wdata;
            end
            if (s_valid && s_ready) begin
                split_q = {split_q,
                           rho_split(s_number, s_start_value, s_increment, round_limit)};
                delta++;
            end
            if (m_valid && m_ready) begin
                if (split_q.size() == 0) begin
                    report("unexpected result, factor", m_factor, 0);
                end else begin
                    exp_split = split_q.pop_front();
                    delta--;
                    if (m_factor !== exp_split.factor)
                        report("factor", m_factor, exp_split.factor);
                    if (m_status !== exp_split.status)
                        report("status", m_status, exp_split.status);
                end
            end
            pending <= pending + delta;
        end
    end
endmodule

// ===== tb/tb_pollard_rho_factor_finder_core.sv =====
`timescale 1ns / 1ps
module tb_pollard_rho_factor_finder_core;
    logic                          aclk;
    logic                          aresetn;
    logic                          s_valid;
    logic                          s_ready;
    prf_pkg::word_t                s_number;
    prf_pkg::word_t                s_start_value;
    prf_pkg::word_t                s_increment;
    logic                          m_valid;
    logic                          m_ready;
    prf_pkg::word_t                m_factor;
    logic [1:0]                    m_status;
    logic                          cfg_we;
    logic [prf_pkg::MaxItBits-1:0] cfg_wdata;
    int                            errors;
    int                            pending;
    logic                          calm;
    int                            sent;
    int                            settings;
    int                            stall_left;

    pollard_rho_factor_finder_core DUT (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_number(s_number),
        .s_start_value(s_start_value), .s_increment(s_increment),
        .m_valid(m_valid), .m_ready(m_ready), .m_factor(m_factor), .m_status(m_status),
        .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
    );

    prf_checker u_checker (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_number(s_number),
        .s_start_value(s_start_value), .s_increment(s_increment),
        .m_valid(m_valid), .m_ready(m_ready), .m_factor(m_factor), .m_status(m_status),
        .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .errors(errors), .pending(pending)
    );

    initial aclk = 0;
    always #1 aclk = ~aclk;

    // The receiver drops m_ready in random bursts unless calm.
    always @(posedge aclk) begin
        if (calm || !aresetn) begin
            m_ready <= 1'b1;
            stall_left <= 0;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            m_ready <= (stall_left == 1);
        end else if ($urandom_range(0, 5) == 0) begin
            stall_left <= $urandom_range(1, 8);
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    task automatic send_item(input prf_pkg::word_t n, input prf_pkg::word_t sv,
                             input prf_pkg::word_t inc);
        int gap;
        gap = (!calm && $urandom_range(0, 3) == 0) ? $urandom_range(1, 8) : 0;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_number      <= n;
        s_start_value <= sv;
        s_increment   <= inc;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sent++;
    endtask

    task automatic drain;
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);
    endtask

    task automatic set_limit(input logic [prf_pkg::MaxItBits-1:0] lim);
        drain();
        cfg_we    <= 1'b1;
        cfg_wdata <= lim;
        @(posedge aclk);
        cfg_we    <= 1'b0;
        settings++;
    endtask

    // An odd number with a small prime factor, so the search ends in a few rounds.
    function automatic prf_pkg::word_t easy_odd();
        int unsigned    p;
        prf_pkg::word_t m;
        case ($urandom_range(0, 4))
            0: p = 3;
            1: p = 5;
            2: p = 7;
            3: p = 11;
            default: p = 13;
        endcase
        m = $urandom_range(1, 32'hFFFF_FFFF / p) | 1;
        return p * m;
    endfunction

    function automatic prf_pkg::word_t any_number();
        int unsigned k;
        k = $urandom_range(0, 9);
        if (k == 0) return 1;
        if (k == 1) return $urandom & ~32'd1;
        if (k < 5) return $urandom | 1;
        return easy_odd();
    endfunction

    initial begin
        aresetn   = 1'b0;
        s_valid   = 1'b0;
        s_number  = '0;
        s_start_value = '0;
        s_increment   = '0;
        cfg_we    = 1'b0;
        cfg_wdata = '0;
        m_ready   = 1'b1;
        calm      = 1'b0;
        sent      = 0;
        settings  = 0;
        stall_left = 0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed items under the reset limit.
        send_item(1, $urandom, $urandom);
        send_item(2, 0, 0);
        send_item(0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_item(32'hFFFF_FFFE, 5, 7);
        send_item(9, 0, 0);                       // zero increment, difference stays zero
        send_item(15, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_item(32'hFFFF_FFFF, 2, 1);
        send_item(32'hFFFF_FFFF, 32'hFFFF_FFFE, 0);
        send_item(3 * 1431655761, 2, 1);
        send_item(21, 40, 100);                   // seeds above the number
        send_item(77, 2, 1);
        send_item(easy_odd(), $urandom, $urandom);

        set_limit(1);
        send_item(32'hFFFF_FFFB, 2, 1);           // prime, gives up after one round
        send_item(32'hFFFF_FFFB, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_item(3, 1, 1);
        send_item($urandom | 1, $urandom, $urandom);

        set_limit(20'hFFFFF);
        send_item(easy_odd(), $urandom, $urandom);
        send_item(easy_odd(), 0, 0);
        send_item(25, 3, 2);
        send_item(1, 0, 0);

        // Random phases under small limits keep every prime search short.
        for (int ph = 0; ph < 9; ph++) begin
            set_limit($urandom_range(1, 8));
            if (ph == 7) calm = 1'b1;
            for (int i = 0; i < 10; i++)
                send_item(any_number(), $urandom, $urandom);
        end
        set_limit(prf_pkg::MaxItReset);
        for (int i = 0; i < 5; i++)
            send_item(easy_odd(), $urandom, $urandom);

        drain();
        repeat (50) @(posedge aclk);
        $display("Ran %0d items over %0d limit settings, from 1 round up to the maximum.",
                 sent, settings + 1);
        if (errors == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    initial begin
        #60_000_000;
        $display("Timeout with %0d results outstanding.", pending);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule
